/* rtl/bbmv_pkg.sv */
// bbmv_pkg.sv: shared types, constants and rounding helpers for the billboard matrix unit
`timescale 1ns / 1ps
package bbmv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC  = 30;
  localparam int ANG_SH    = ANG_FRAC - FRAC_BITS;
  localparam int RED_STEPS = ANG_SH;               // restoring steps of the mod 2*pi reduction
  localparam int ZW        = 34 + ANG_SH;          // angle width during reduction
  localparam int CW        = 34;                   // cordic datapath width
  localparam int ITERS     = 30;
  localparam int SUMW      = 64 - FRAC_BITS + 3;   // sum of four rounded products
  localparam int NUM_REGS  = 8;
  localparam int IDXW      = 4;

  localparam logic signed [ZW-1:0] TWO_PI  = ZW'(64'sd6746518852);
  localparam logic signed [ZW-1:0] PI_V    = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN    = CW'(64'sd652032874);

  localparam logic [63:0] REG_RESET [0:NUM_REGS-1] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  localparam logic [31:0] ATAN_TAB [0:ITERS-1] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
    32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
    32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
    32'd31, 32'd15, 32'd8, 32'd4, 32'd2
  };

  typedef logic signed [31:0]     q_t;
  typedef logic signed [63:0]     prod_t;
  typedef logic signed [SUMW-1:0] sum_t;

  // one value of the angle pipeline
  typedef struct packed {
    q_t                   px;
    q_t                   py;
    q_t                   pz;
    q_t                   sc;
    logic signed [ZW-1:0] z;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 neg;
  } pipe_t;

  function automatic prod_t mul(input q_t a, input q_t b);
    mul = prod_t'(a) * prod_t'(b);
  endfunction

  // round half up to FRAC_BITS fraction bits
  function automatic sum_t rnd(input prod_t p);
    prod_t t;
    t = p + (prod_t'(1) <<< (FRAC_BITS - 1));
    rnd = SUMW'(t >>> FRAC_BITS);
  endfunction

  function automatic q_t sat32(input sum_t v);
    if (v > sum_t'(64'sd2147483647)) sat32 = 32'sh7fffffff;
    else if (v < -sum_t'(64'sd2147483648)) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

/* rtl/billboard_model_view_matrix_unit.sv */
// billboard_model_view_matrix_unit.sv: spherical billboard model-view matrix pipeline
`timescale 1ns / 1ps
// Takes one particle transaction (position, angle, scale) and returns its 4x4
// model-view matrix as four column transactions, column 0 first, against the
// view matrix held in eight 64-bit registers. The angle goes through a
// restoring mod 2*pi reduction (one quotient bit per stage), a fold stage and
// thirty registered cordic stages; rotation and scale each take a product stage
// and a round/saturate stage. The final view product shares sixteen
// multipliers across the four columns of one matrix, so the block returns
// one column per cycle while the receiver is ready; a new particle may enter
// the pipeline every cycle until that column stage backs up. The user must
// write the registers only while the block is idle; the block itself does
// not enforce it.
module billboard_model_view_matrix_unit
  import bbmv_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  q_t              pos_x,
  input  q_t              pos_y,
  input  q_t              pos_z,
  input  q_t              angle,
  input  q_t              size_factor,
  output logic            out_valid,
  input  logic            out_ready,
  output q_t              elem_row0,
  output q_t              elem_row1,
  output q_t              elem_row2,
  output q_t              elem_row3,
  output logic [1:0]      column_index,
  output logic            last_column,
  input  logic            cfg_we,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [63:0]     cfg_data
);

  localparam int NST  = RED_STEPS + ITERS + 3;
  localparam int FOLD = RED_STEPS + 1;
  localparam int LAST = NST - 1;

  logic [63:0] view [0:NUM_REGS-1];

  // view element (column, row)
  function automatic q_t vel(input int col, input int row);
    logic [63:0] w;
    w = view[(col * 2 + row / 2) % NUM_REGS];
    vel = (row % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) view[i] <= REG_RESET[i];
    end else if (cfg_we && cfg_index < IDXW'(NUM_REGS)) begin
      view[cfg_index[2:0]] <= cfg_data;
    end
  end

  // global advance of everything ahead of the column stage
  logic adv;
  logic p_adv;

  // ---------------- angle pipeline ----------------
  pipe_t st     [0:NST-1];
  pipe_t st_next[0:NST-1];
  logic  sv     [0:NST-1];

  always_comb begin
    st_next[0]     = '0;
    st_next[0].px  = pos_x;
    st_next[0].py  = pos_y;
    st_next[0].pz  = pos_z;
    st_next[0].sc  = size_factor;
    // offset by a multiple of 2*pi so the value is never negative
    st_next[0].z   = (ZW'(angle) <<< ANG_SH) + (TWO_PI <<< (RED_STEPS - 1));
  end

  genvar j;
  generate
    for (j = 1; j <= RED_STEPS; j++) begin : g_red
      localparam int K = RED_STEPS - j;
      always_comb begin
        st_next[j] = st[j-1];
        if (st[j-1].z >= (TWO_PI <<< K)) st_next[j].z = st[j-1].z - (TWO_PI <<< K);
      end
    end

    for (j = 0; j < ITERS; j++) begin : g_cordic
      localparam int S = FOLD + 1 + j;
      always_comb begin
        st_next[S] = st[S-1];
        if (st[S-1].z >= 0) begin
          st_next[S].x = st[S-1].x - (st[S-1].y >>> j);
          st_next[S].y = st[S-1].y + (st[S-1].x >>> j);
          st_next[S].z = st[S-1].z - ZW'(ATAN_TAB[j]);
        end else begin
          st_next[S].x = st[S-1].x + (st[S-1].y >>> j);
          st_next[S].y = st[S-1].y - (st[S-1].x >>> j);
          st_next[S].z = st[S-1].z + ZW'(ATAN_TAB[j]);
        end
      end
    end

    for (j = 0; j < NST; j++) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) sv[j] <= 1'b0;
        else if (adv) sv[j] <= (j == 0) ? in_valid : sv[(j == 0) ? 0 : j - 1];
      end
      always_ff @(posedge clk) begin
        if (adv) st[j] <= st_next[j];
      end
    end
  endgenerate

  // fold into [-pi/2, pi/2]; a fold by pi flips both results
  always_comb begin
    logic signed [ZW-1:0] zf;
    st_next[FOLD] = st[FOLD-1];
    zf = st[FOLD-1].z;
    if (zf > PI_V) zf = zf - TWO_PI;
    st_next[FOLD].neg = 1'b0;
    if (zf > HALF_PI) begin
      zf = zf - PI_V;
      st_next[FOLD].neg = 1'b1;
    end else if (zf < -HALF_PI) begin
      zf = zf + PI_V;
      st_next[FOLD].neg = 1'b1;
    end
    st_next[FOLD].z = zf;
    st_next[FOLD].x = GAIN;
    st_next[FOLD].y = '0;
  end

  // sign fix and rounding to FRAC_BITS: x carries cos, y carries sin
  always_comb begin
    logic signed [CW-1:0] xs, ys;
    st_next[LAST] = st[LAST-1];
    xs = st[LAST-1].neg ? -st[LAST-1].x : st[LAST-1].x;
    ys = st[LAST-1].neg ? -st[LAST-1].y : st[LAST-1].y;
    st_next[LAST].x = (xs + (CW'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
    st_next[LAST].y = (ys + (CW'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
  end

  q_t cs, sn;
  assign cs = st[LAST].x[31:0];
  assign sn = st[LAST].y[31:0];

  // ---------------- rotation ----------------
  logic  rp_valid;
  prod_t rp_c0 [0:3], rp_s0 [0:3], rp_c1 [0:3], rp_s1 [0:3];
  q_t    rp_px, rp_py, rp_pz, rp_sc;

  always_ff @(posedge clk) begin
    if (rst) rp_valid <= 1'b0;
    else if (adv) rp_valid <= sv[LAST];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        rp_c0[r] <= mul((r < 3) ? vel(r, 0) : q_t'(0), cs);
        rp_s0[r] <= mul((r < 3) ? vel(r, 1) : q_t'(0), sn);
        rp_c1[r] <= mul((r < 3) ? vel(r, 1) : q_t'(0), cs);
        rp_s1[r] <= mul((r < 3) ? vel(r, 0) : q_t'(0), sn);
      end
      rp_px <= st[LAST].px;
      rp_py <= st[LAST].py;
      rp_pz <= st[LAST].pz;
      rp_sc <= st[LAST].sc;
    end
  end

  logic rs_valid;
  q_t   rs_m0 [0:3], rs_m1 [0:3];
  q_t   rs_px, rs_py, rs_pz, rs_sc;

  always_ff @(posedge clk) begin
    if (rst) rs_valid <= 1'b0;
    else if (adv) rs_valid <= rp_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        rs_m0[r] <= sat32(rnd(rp_c0[r]) + rnd(rp_s0[r]));
        rs_m1[r] <= sat32(rnd(rp_c1[r]) - rnd(rp_s1[r]));
      end
      rs_px <= rp_px;
      rs_py <= rp_py;
      rs_pz <= rp_pz;
      rs_sc <= rp_sc;
    end
  end

  // ---------------- scale ----------------
  logic  sp_valid;
  prod_t sp_p [0:2][0:3];
  q_t    sp_px, sp_py, sp_pz;

  always_ff @(posedge clk) begin
    if (rst) sp_valid <= 1'b0;
    else if (adv) sp_valid <= rs_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        sp_p[0][r] <= mul(rs_m0[r], rs_sc);
        sp_p[1][r] <= mul(rs_m1[r], rs_sc);
        sp_p[2][r] <= mul((r < 3) ? vel(r, 2) : q_t'(0), rs_sc);
      end
      sp_px <= rs_px;
      sp_py <= rs_py;
      sp_pz <= rs_pz;
    end
  end

  // ---------------- model matrix, held while its columns go out ----------------
  logic       f_valid;
  logic [1:0] f_col;
  q_t         f_m [0:3][0:3];

  assign p_adv    = !out_valid || out_ready;
  assign adv      = !f_valid || (p_adv && f_col == 2'd3);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      f_col   <= 2'd0;
    end else begin
      if (adv) f_valid <= sp_valid;
      if (p_adv && f_valid) f_col <= f_col + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 4; r++) f_m[c][r] <= sat32(rnd(sp_p[c][r]));
      f_m[3][0] <= sp_px;
      f_m[3][1] <= sp_py;
      f_m[3][2] <= sp_pz;
      f_m[3][3] <= q_t'(1) <<< FRAC_BITS;
    end
  end

  // ---------------- view product, one column per cycle unless stalled ----------------
  logic       p_valid;
  logic [1:0] p_col;
  prod_t      p_prod [0:3][0:3];

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (p_adv) p_valid <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      p_col <= f_col;
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++) p_prod[r][k] <= mul(vel(k, r), f_m[f_col][k]);
    end
  end

  // output register
  q_t o_row [0:3];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (p_adv) out_valid <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      for (int r = 0; r < 4; r++)
        o_row[r] <= sat32(rnd(p_prod[r][0]) + rnd(p_prod[r][1])
                          + rnd(p_prod[r][2]) + rnd(p_prod[r][3]));
      column_index <= p_col;
      last_column  <= (p_col == 2'd3);
    end
  end

  assign elem_row0 = o_row[0];
  assign elem_row1 = o_row[1];
  assign elem_row2 = o_row[2];
  assign elem_row3 = o_row[3];

endmodule

/* verif/tb_billboard_model_view_matrix_unit.sv */
// testbench for the billboard model-view matrix unit with a column scoreboard
`timescale 1ns / 1ps
module tb_billboard_model_view_matrix_unit;
  import bbmv_pkg::*;

  // one expected column transaction
  typedef struct {
    q_t         row [4];
    logic [1:0] col;
    logic       last;
  } column_t;

  localparam logic [IDXW-1:0] IDX_BOGUS = IDXW'(NUM_REGS + 3);

  // scoreboard: predicts the four columns per particle and checks them in order
  class column_scoreboard;
    logic [63:0] view_regs [NUM_REGS];
    column_t     pending [$];
    int          mismatches;

    function void reset_view();
      for (int i = 0; i < NUM_REGS; i++) view_regs[i] = REG_RESET[i];
    endfunction

    function void write_view(logic [IDXW-1:0] idx, logic [63:0] data);
      if (idx < NUM_REGS) view_regs[idx] = data;
    endfunction

    function longint view_elem(int c, int r);
      logic [63:0] w;
      w = view_regs[(c * 2 + (r >> 1)) & 7];
      return (r & 1) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
    endfunction

    // >>> on longint is an arithmetic floor shift
    function longint fixmul(longint a, longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void sin_cos(longint ang, output longint sn, output longint cs);
      longint z, x, y, nx;
      longint atan_v [ITERS];
      bit     flip;
      for (int i = 0; i < ITERS; i++) atan_v[i] = longint'(ATAN_TAB[i]);
      z = ang * (longint'(1) <<< ANG_SH);
      x = 652032874;
      y = 0;
      flip = 0;
      z = z % 64'sd6746518852;
      if (z < 0) z += 64'sd6746518852;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426;
        flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426;
        flip = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_v[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_v[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      cs = (x + (longint'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
      sn = (y + (longint'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
    endfunction

    function void note_particle(q_t px, q_t py, q_t pz, q_t ang, q_t scale);
      longint  m [4][4];
      longint  sn, cs, a0, a1, acc;
      column_t e;
      sin_cos(longint'(ang), sn, cs);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) m[c][r] = 0;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) m[c][r] = view_elem(r, c);
      m[3][0] = px;
      m[3][1] = py;
      m[3][2] = pz;
      m[3][3] = longint'(1) <<< FRAC_BITS;
      for (int r = 0; r < 4; r++) begin
        a0 = m[0][r];
        a1 = m[1][r];
        m[0][r] = clip(fixmul(a0, cs) + fixmul(a1, sn));
        m[1][r] = clip(fixmul(a1, cs) - fixmul(a0, sn));
      end
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 4; r++) m[c][r] = clip(fixmul(m[c][r], longint'(scale)));
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fixmul(view_elem(k, r), m[c][k]);
          e.row[r] = q_t'(clip(acc));
        end
        e.col = c[1:0];
        e.last = (c == 3);
        pending.push_back(e);
      end
    endfunction

    function void check_column(q_t r0, q_t r1, q_t r2, q_t r3, logic [1:0] ci, logic lc);
      column_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column transaction col=%0d", ci);
        return;
      end
      e = pending.pop_front();
      if (e.row[0] !== r0 || e.row[1] !== r1 || e.row[2] !== r2 || e.row[3] !== r3 ||
          e.col !== ci || e.last !== lc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("column mismatch exp %h %h %h %h c%0d l%0d got %h %h %h %h c%0d l%0d",
                   e.row[0], e.row[1], e.row[2], e.row[3], e.col, e.last,
                   r0, r1, r2, r3, ci, lc);
      end
    endfunction
  endclass

  logic            clk = 0;
  logic            rst = 1;
  logic            in_valid = 0;
  logic            in_ready;
  q_t              pos_x = 0, pos_y = 0, pos_z = 0, angle = 0, size_factor = 0;
  logic            out_valid;
  logic            out_ready = 0;
  q_t              elem_row0, elem_row1, elem_row2, elem_row3;
  logic [1:0]      column_index;
  logic            last_column;
  logic            cfg_we = 0;
  logic [IDXW-1:0] cfg_index = 0;
  logic [63:0]     cfg_data = 0;

  column_scoreboard sb = new();
  int send_idle_pct = 0;   // chance in percent that the sender skips a cycle
  int recv_idle_pct = 0;   // chance in percent that the receiver stalls

  always #1 clk = ~clk;

  billboard_model_view_matrix_unit u_top (.*);

  // receiver: random back-pressure, check every accepted column
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_column(elem_row0, elem_row1, elem_row2, elem_row3, column_index, last_column);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // drive one particle, with an optional random gap first
  // valid stays high after acceptance so back-to-back particles need no extra edge
  task automatic send_particle(q_t px, q_t py, q_t pz, q_t ang, q_t scale);
    cfg_we <= 0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid    <= 1;
    pos_x       <= px;
    pos_y       <= py;
    pos_z       <= pz;
    angle       <= ang;
    size_factor <= scale;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_particle(px, py, pz, ang, scale);
  endtask

  // write enable stays high until the next particle goes out
  task automatic write_reg(logic [IDXW-1:0] idx, logic [63:0] data);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_view(idx, data);
  endtask

  // wait until every column has arrived, plus the pipeline latency
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(5))
      0: return q_t'($urandom());
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return q_t'($urandom_range(32'h60000)) - 32'sh30000;
    endcase
  endfunction

  function automatic q_t rand_small();
    return q_t'($urandom_range(32'h40000)) - 32'sh20000;
  endfunction

  // random view matrix, mostly small well-conditioned values
  task automatic random_view(bit wild);
    for (int i = 0; i < NUM_REGS; i++)
      if (wild) write_reg(IDXW'(i), {$urandom(), $urandom()});
      else write_reg(IDXW'(i), {32'($signed(rand_small())), 32'($signed(rand_small()))});
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++)
      send_particle(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  initial begin
    sb.reset_view();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 74;

    // directed: identity view, extremes of every field and notable angles
    send_particle(0, 0, 0, 0, 32'sh10000);
    send_particle(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_particle(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_particle(32'sh10000, 32'sh20000, 32'sh30000, 32'sh1921f, 32'sh10000);  // about pi/2
    send_particle(32'sh10000, 32'sh20000, 32'sh30000, 32'sh3243f, 32'sh20000);  // about pi
    send_particle(32'sh10000, 32'sh20000, 32'sh30000, -32'sh3243f, -32'sh10000);
    send_particle(-1, 1, -1, 32'sh6487f, 32'sh8000);                            // about 2*pi
    send_particle(0, 0, 0, -1, 0);
    drain();

    // extreme view forces saturation in the final product
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDXW'(i), 64'h7fffffff_7fffffff);
    write_reg(IDX_BOGUS, 64'h0);  // unknown index, ignored
    send_particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh1000, 32'sh7fffffff);
    send_particle(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 32'sh80000000);
    drain();
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDXW'(i), 64'h80000000_80000000);
    send_particle(32'sh7fffffff, 32'sh80000000, 32'sh10000, 32'sh7fffffff, 32'sh7fffffff);
    drain();

    // random phases with different idling and view settings
    random_view(0);
    random_batch(50);
    drain();
    send_idle_pct = 74;
    recv_idle_pct = 22;
    random_view(1);
    random_batch(50);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDXW'(i), REG_RESET[i]);
    random_batch(30);
    drain();
    random_view(0);
    random_batch(30);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
